// ----- design/csl_pkg.sv -----
// shared types, constants and character-class helpers for the c-subset lexer
`default_nettype none

package csl_pkg;

    // default parameter values
    localparam int DEF_MAX_LEXEME    = 127;
    localparam int DEF_POSITION_BITS = 32;

    // fixed port widths
    localparam int KIND_W   = 5;
    localparam int START_W  = 32;
    localparam int LENGTH_W = 7;

    // keyword table geometry
    localparam int NUM_KW       = 6;
    localparam int KW_MAX_CHARS = 8;
    localparam int KW_IDX_W     = 3;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef logic [KIND_W-1:0] kind_t;

    // token kinds
    localparam kind_t KIND_INT     = 5'd0;
    localparam kind_t KIND_FLOAT   = 5'd1;
    localparam kind_t KIND_DOUBLE  = 5'd2;
    localparam kind_t KIND_CHAR    = 5'd3;
    localparam kind_t KIND_BOOLEAN = 5'd4;
    localparam kind_t KIND_ID      = 5'd5;
    localparam kind_t KIND_INTNUM  = 5'd6;
    localparam kind_t KIND_DECNUM  = 5'd7;
    localparam kind_t KIND_ASSIGN  = 5'd8;
    localparam kind_t KIND_SEMI    = 5'd9;
    localparam kind_t KIND_LBRACE  = 5'd10;
    localparam kind_t KIND_RBRACE  = 5'd11;
    localparam kind_t KIND_LPAREN  = 5'd12;
    localparam kind_t KIND_RPAREN  = 5'd13;
    localparam kind_t KIND_COMMA   = 5'd14;
    localparam kind_t KIND_PLUS    = 5'd15;
    localparam kind_t KIND_MINUS   = 5'd16;
    localparam kind_t KIND_STAR    = 5'd17;
    localparam kind_t KIND_SLASH   = 5'd18;
    localparam kind_t KIND_RETURN  = 5'd19;
    localparam kind_t KIND_END     = 5'd20;

    localparam logic [7:0] CHAR_DOT = 8'h2e;

    // keyword spellings, zero padded
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_CHARS] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
        '{"d", "o", "u", "b", "l", "e", 8'h00, 8'h00},
        '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", "o", "o", "l", "e", "a", "n", 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
    };
    localparam logic [KW_IDX_W-1:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd5, 3'd6, 3'd4, 3'd7, 3'd6
    };
    localparam kind_t KW_KIND [NUM_KW] = '{
        KIND_INT, KIND_FLOAT, KIND_DOUBLE, KIND_CHAR, KIND_BOOLEAN, KIND_RETURN
    };

    // scanner state, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_IDENT   = 4'b0010,
        MODE_INTEGER = 4'b0100,
        MODE_DECIMAL = 4'b1000
    } mode_t;

    // one emitted token
    typedef struct packed {
        kind_t               kind;
        logic [START_W-1:0]  start;
        logic [LENGTH_W-1:0] length;
        logic                last;
    } tok_t;

    // punctuation lookup result
    typedef struct packed {
        logic  hit;
        kind_t kind;
    } punct_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0d]};
    endfunction

    function automatic punct_t punct_lookup(input logic [7:0] c);
        punct_t p;
        p.hit = 1'b1;
        case (c)
            "=":     p.kind = KIND_ASSIGN;
            ";":     p.kind = KIND_SEMI;
            "{":     p.kind = KIND_LBRACE;
            "}":     p.kind = KIND_RBRACE;
            "(":     p.kind = KIND_LPAREN;
            ")":     p.kind = KIND_RPAREN;
            ",":     p.kind = KIND_COMMA;
            "+":     p.kind = KIND_PLUS;
            "-":     p.kind = KIND_MINUS;
            "*":     p.kind = KIND_STAR;
            "/":     p.kind = KIND_SLASH;
            default:
            begin
                p.hit  = 1'b0;
                p.kind = KIND_END;
            end
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- design/c_subset_lexer_top.sv -----
// c-subset lexer: byte-stream tokenizer with a small result queue
//
// usage: source bytes enter on the input channel (in_valid / in_stall), one
// byte per transaction; end_of_input set in a transaction flushes any pending
// token and gives an end token (src_byte is then ignored). tokens leave on the
// output channel (out_valid / out_stall) with kind, start offset, length and
// last_of_run, which marks the final token caused by one input transaction.
// a token is written into the result queue registers when the byte that
// completes it is accepted, and the output shows the queue head.
// throughput: one byte per cycle while the output is drained; the scanner
// state updates in the same cycle a byte is accepted. a byte can produce two
// tokens (pending token plus punctuation or end token), and the output moves
// one token per cycle, so the four-entry result queue sets the rate: input
// stall rises whenever fewer than two queue entries are free.
// reset: scanner returns to idle, byte offset to zero, queue empties.
// output stall: tokens wait in the queue and input keeps flowing until the
// queue is nearly full, then in_stall holds the input side.
`default_nettype none

module c_subset_lexer_top #(
    parameter int MAX_LEXEME    = csl_pkg::DEF_MAX_LEXEME,
    parameter int POSITION_BITS = csl_pkg::DEF_POSITION_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [7:0]                   src_byte,
    input  wire logic                         end_of_input,
    // output channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output csl_pkg::kind_t                    token_kind,
    output logic [csl_pkg::START_W-1:0]       token_start,
    output logic [csl_pkg::LENGTH_W-1:0]      token_length,
    output logic                              last_of_run
);
    import csl_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEXEME + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEXEME);

    // scanner state
    mode_t                    mode_reg,  mode_next;
    logic [NUM_KW-1:0]        cand_reg,  cand_next;
    logic [LEN_W-1:0]         len_reg,   len_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [POSITION_BITS-1:0] pos_reg,   pos_next;

    // result queue
    tok_t             fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    logic       in_fire;
    logic       out_fire;
    logic [1:0] n_res;
    tok_t       res0;
    tok_t       res1;
    tok_t       flush_tok;
    tok_t       new_tok;
    logic       flush_v;
    logic       new_v;
    kind_t      flush_kind;
    logic       pending;
    logic       extend;
    logic       to_decimal;
    punct_t     punct;

    // drop keyword candidates that disagree with char c at offset idx
    function automatic logic [NUM_KW-1:0] kw_filter(
        input logic [NUM_KW-1:0] cand,
        input logic [LEN_W-1:0]  idx,
        input logic [7:0]        c
    );
        logic [NUM_KW-1:0] keep;
        keep = cand;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (idx >= LEN_W'(KW_LEN[k]) || KW_TEXT[k][idx[KW_IDX_W-1:0]] != c)
            begin
                keep[k] = 1'b0;
            end
        end
        return keep;
    endfunction

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;
    assign in_stall = count_reg > CNT_W'(FIFO_DEPTH - 2);
    assign pending  = mode_reg != MODE_IDLE;
    assign punct    = punct_lookup(src_byte);

    // kind of the pending token if it ends now
    always_comb
    begin
        flush_kind = KIND_INTNUM;
        case (mode_reg)
            MODE_IDENT:
            begin
                flush_kind = KIND_ID;
                for (int k = NUM_KW - 1; k >= 0; k--)
                begin
                    if (cand_reg[k] && len_reg == LEN_W'(KW_LEN[k]))
                    begin
                        flush_kind = KW_KIND[k];
                    end
                end
            end
            MODE_DECIMAL: flush_kind = KIND_DECNUM;
            default:      flush_kind = KIND_INTNUM;
        endcase
    end

    // does the byte continue the pending token
    always_comb
    begin
        extend     = 1'b0;
        to_decimal = 1'b0;
        case (mode_reg)
            MODE_IDENT:   extend = is_alpha(src_byte) || is_digit(src_byte);
            MODE_INTEGER:
            begin
                to_decimal = src_byte == CHAR_DOT;
                extend     = is_digit(src_byte) || to_decimal;
            end
            MODE_DECIMAL: extend = is_digit(src_byte);
            default:      extend = 1'b0;
        endcase
    end

    // scanner next state and emitted tokens
    always_comb
    begin
        mode_next  = mode_reg;
        cand_next  = cand_reg;
        len_next   = len_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        flush_v    = 1'b0;
        new_v      = 1'b0;

        flush_tok.kind   = flush_kind;
        flush_tok.start  = START_W'(start_reg);
        flush_tok.length = LENGTH_W'(len_reg);
        flush_tok.last   = 1'b0;

        new_tok.kind   = KIND_END;
        new_tok.start  = START_W'(pos_reg);
        new_tok.length = '0;
        new_tok.last   = 1'b1;

        if (in_fire)
        begin
            if (end_of_input)
            begin
                flush_v   = pending;
                new_v     = 1'b1;
                mode_next = MODE_IDLE;
                cand_next = '1;
                len_next  = '0;
            end
            else
            begin
                pos_next = pos_reg + POSITION_BITS'(1);
                if (extend)
                begin
                    if (mode_reg == MODE_IDENT)
                    begin
                        cand_next = kw_filter(cand_reg, len_reg, src_byte);
                    end
                    if (len_reg < LEN_MAX)
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                    if (to_decimal)
                    begin
                        mode_next = MODE_DECIMAL;
                    end
                end
                else
                begin
                    flush_v   = pending;
                    mode_next = MODE_IDLE;
                    cand_next = '1;
                    len_next  = '0;
                    if (is_alpha(src_byte))
                    begin
                        mode_next  = MODE_IDENT;
                        cand_next  = kw_filter('1, '0, src_byte);
                        len_next   = LEN_W'(1);
                        start_next = pos_reg;
                    end
                    else if (is_digit(src_byte))
                    begin
                        mode_next  = MODE_INTEGER;
                        len_next   = LEN_W'(1);
                        start_next = pos_reg;
                    end
                    else if (punct.hit)
                    begin
                        new_v          = 1'b1;
                        new_tok.kind   = punct.kind;
                        new_tok.length = LENGTH_W'(1);
                    end
                end
            end
        end

        // order: pending token first, last_of_run on the final one
        flush_tok.last = !new_v;
        n_res = {1'b0, flush_v} + {1'b0, new_v};
        res0  = flush_v ? flush_tok : new_tok;
        res1  = new_tok;
    end

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_res);
        rd_ptr_next = rd_ptr_reg + PTR_W'(out_fire);
        count_next  = count_reg + CNT_W'(n_res) - CNT_W'(out_fire);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            cand_reg   <= '1;
            len_reg    <= '0;
            start_reg  <= '0;
            pos_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            cand_reg   <= cand_next;
            len_reg    <= len_next;
            start_reg  <= start_next;
            pos_reg    <= pos_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (n_res == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    // output side
    assign out_valid    = count_reg != '0;
    assign token_kind   = fifo_mem[rd_ptr_reg].kind;
    assign token_start  = fifo_mem[rd_ptr_reg].start;
    assign token_length = fifo_mem[rd_ptr_reg].length;
    assign last_of_run  = fifo_mem[rd_ptr_reg].last;

    // queue never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count above depth");

    // an accepted byte always finds room for two tokens
    a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> count_reg <= CNT_W'(FIFO_DEPTH - 2))
        else $error("byte accepted without room for two tokens");

    // end token always closes its transaction
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_END |-> last_of_run)
        else $error("end token without last_of_run");

    // idle scanner holds no lexeme
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_IDLE |-> len_reg == '0 && cand_reg == '1)
        else $error("idle scanner with pending lexeme state");

    // an end transaction leaves the scanner idle and the offset unchanged
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && end_of_input |=> mode_reg == MODE_IDLE && pos_reg == $past(pos_reg))
        else $error("end transaction did not return scanner to idle");

endmodule

`default_nettype wire
